### src/assert_macros.svh
// Assertion macros shared by the decoder RTL; they expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/u8d_pkg.sv
// Package: constants and types of the UTF-8 decoder.
package u8d_pkg;

    localparam int OFFSET_W = 32;
    localparam int MAX_RES  = 4;
    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic [20:0] REPL_CP = 21'h00FFFD;
    localparam logic [20:0] MAX_CP  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;

    localparam logic [7:0] ASCII_HI  = 8'h7F;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    localparam logic [16:0] MIN2 = 17'h00080;
    localparam logic [16:0] MIN3 = 17'h00800;
    localparam logic [16:0] MIN4 = 17'h10000;

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic [31:0] start_offset;
        logic [2:0]  byte_length;
        logic        last_result;
    } t_result;

    // results of one byte, slots below cnt are valid
    typedef struct packed {
        logic [2:0]                 cnt;
        t_result [MAX_RES-1:0]      res;
    } t_push;

endpackage

### src/u8d_if.sv
// Handshake interfaces for the byte input and the code point output.
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic [31:0] start_offset;
    logic [2:0]  byte_length;
    logic        last_result;

    modport source (output valid, output code_point, output replaced, output start_offset,
                    output byte_length, output last_result, input ready);
    modport sink   (input valid, input code_point, input replaced, input start_offset,
                    input byte_length, input last_result, output ready);
endinterface

### src/u8d_dec.sv
// Input register, sequence state and per-byte decode into up to four results.
`include "assert_macros.svh"

module u8d_dec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u8d_in_if.sink         i_in,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic           i_room,
    output u8d_pkg::t_push o_push
);
    import u8d_pkg::*;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_eot;
    logic                r_replace_nul;
    logic [2:0]          r_exp_len;
    logic [1:0]          r_held;
    logic [20:0]         r_part;
    logic [16:0]         r_min;
    logic [OFFSET_W-1:0] r_pos;
    logic [OFFSET_W-1:0] r_seq_start;

    logic                take;
    logic                cont;
    logic                seq_open;
    logic                do_lead;
    logic                keep;
    logic                bad;
    logic [2:0]          held_nx;
    logic [20:0]         part_nx;
    logic [2:0]          flush_cnt;
    logic                has_single;
    logic [20:0]         single_cp;
    logic                single_rep;
    logic [OFFSET_W-1:0] single_start;
    logic [2:0]          single_len;
    logic [2:0]          lead_len;
    logic [20:0]         lead_val;
    logic [16:0]         lead_min;
    logic [2:0]          n_cnt;

    assign take       = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || i_room;

    assign held_nx = 3'(r_held) + 3'd1;
    assign part_nx = {r_part[14:0], r_in_byte[5:0]};
    assign bad     = (part_nx < 21'(r_min)) || (part_nx > MAX_CP)
                     || ((part_nx >= SURR_LO) && (part_nx <= SURR_HI));

    always_comb begin
        cont         = (r_in_byte & CONT_MASK) == CONT_TAG;
        seq_open     = r_exp_len != 3'd0;
        flush_cnt    = 3'd0;
        has_single   = 1'b0;
        single_cp    = REPL_CP;
        single_rep   = 1'b1;
        single_start = r_pos;
        single_len   = 3'd1;
        lead_len     = 3'd0;
        lead_val     = 21'd0;
        lead_min     = 17'd0;
        keep         = 1'b0;
        do_lead      = 1'b1;
        if (seq_open) begin
            if (cont) begin
                do_lead = 1'b0;
                if (held_nx >= r_exp_len) begin
                    if (bad) begin
                        flush_cnt = r_exp_len;
                    end else begin
                        has_single   = 1'b1;
                        single_cp    = part_nx;
                        single_rep   = 1'b0;
                        single_start = r_seq_start;
                        single_len   = r_exp_len;
                    end
                end else if (r_in_eot) begin
                    flush_cnt = held_nx;
                end else begin
                    keep = 1'b1;
                end
            end else begin
                // broken sequence: replace what is held, then retry the byte as a lead
                flush_cnt = 3'(r_held);
            end
        end
        if (do_lead) begin
            unique case (r_in_byte) inside
                [8'h00:ASCII_HI]: begin
                    has_single = 1'b1;
                    if (!((r_in_byte == 8'h00) && r_replace_nul)) begin
                        single_cp  = 21'(r_in_byte);
                        single_rep = 1'b0;
                    end
                end
                [LEAD2_LO:LEAD2_HI]: begin
                    lead_len = 3'd2;
                    lead_val = 21'(r_in_byte[4:0]);
                    lead_min = MIN2;
                end
                [LEAD3_LO:LEAD3_HI]: begin
                    lead_len = 3'd3;
                    lead_val = 21'(r_in_byte[3:0]);
                    lead_min = MIN3;
                end
                [LEAD4_LO:LEAD4_HI]: begin
                    lead_len = 3'd4;
                    lead_val = 21'(r_in_byte[2:0]);
                    lead_min = MIN4;
                end
                default: begin
                    has_single = 1'b1;
                end
            endcase
            // a lead on the final byte is truncated
            if ((lead_len != 3'd0) && r_in_eot) begin
                has_single = 1'b1;
            end
        end
    end

    assign n_cnt = flush_cnt + 3'(has_single);

    always_comb begin
        o_push.cnt = take ? n_cnt : 3'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < flush_cnt) begin
                o_push.res[k].code_point   = REPL_CP;
                o_push.res[k].replaced     = 1'b1;
                o_push.res[k].start_offset = 32'(r_seq_start + OFFSET_W'(k));
                o_push.res[k].byte_length  = 3'd1;
            end else begin
                o_push.res[k].code_point   = single_cp;
                o_push.res[k].replaced     = single_rep;
                o_push.res[k].start_offset = 32'(single_start);
                o_push.res[k].byte_length  = single_len;
            end
            o_push.res[k].last_result = r_in_eot && (3'(k) == (n_cnt - 3'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_replace_nul <= 1'b0;
            r_exp_len     <= 3'd0;
            r_held        <= 2'd0;
            r_part        <= 21'd0;
            r_min         <= 17'd0;
            r_pos         <= '0;
            r_seq_start   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_replace_nul <= i_cfg_wr_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take) begin
                r_pos <= r_in_eot ? '0 : r_pos + OFFSET_W'(1);
                if (keep) begin
                    r_held <= held_nx[1:0];
                    r_part <= part_nx;
                end else if (do_lead && (lead_len != 3'd0) && !r_in_eot) begin
                    r_exp_len   <= lead_len;
                    r_held      <= 2'd1;
                    r_part      <= lead_val;
                    r_min       <= lead_min;
                    r_seq_start <= r_pos;
                end else begin
                    r_exp_len <= 3'd0;
                    r_held    <= 2'd0;
                    r_part    <= 21'd0;
                    r_min     <= 17'd0;
                end
            end
        end
    end

    `AST_IMPLY(a_open_state, r_exp_len != 3'd0,
        (r_held != 2'd0) && (3'(r_held) < r_exp_len), "open sequence has bad held count")
    `AST_IMPLY(a_eot_has_result, take && r_in_eot, n_cnt != 3'd0,
        "end-of-text byte produced no result")
    `AST_NEXT(a_eot_closes, take && r_in_eot, (r_pos == '0) && (r_exp_len == 3'd0),
        "end of text left state open")

endmodule

### src/u8d_fifo.sv
// Result queue: takes up to four words per cycle, hands out one per cycle while the sink is ready.
`include "assert_macros.svh"

module u8d_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  u8d_pkg::t_push i_push,
    output logic           o_room,
    u8d_out_if.source      o_out
);
    import u8d_pkg::*;

    t_result             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]    r_wr_ptr;
    logic [RQ_AW-1:0]    r_rd_ptr;
    logic [RQ_CW-1:0]    r_count;
    logic                pop;
    t_result             head;

    assign o_room = r_count <= RQ_CW'(RQ_DEPTH - MAX_RES);
    assign pop    = o_out.valid && o_out.ready;
    assign head   = r_mem[r_rd_ptr];

    assign o_out.valid        = r_count != '0;
    assign o_out.code_point   = head.code_point;
    assign o_out.replaced     = head.replaced;
    assign o_out.start_offset = head.start_offset;
    assign o_out.byte_length  = head.byte_length;
    assign o_out.last_result  = head.last_result;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < i_push.cnt) begin
                r_mem[r_wr_ptr + RQ_AW'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RQ_AW'(i_push.cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RQ_AW'(1);
            end
            r_count <= r_count + RQ_CW'(i_push.cnt) - RQ_CW'(pop);
        end
    end

    `AST_IMPLY(a_push_fits, i_push.cnt != 3'd0, o_room, "words pushed without room")
    `AST_IMPLY(a_no_overfill, 1'b1, r_count <= RQ_CW'(RQ_DEPTH), "queue count overflow")
    `AST_NEXT(a_pop_only, pop && (i_push.cnt == 3'd0),
        r_count == $past(r_count) - RQ_CW'(1), "pop did not lower count")

endmodule

### src/utf8_decoder_with_replacement.sv
// Top level: UTF-8 byte stream decoder that replaces invalid input by U+FFFD.
//
//  channel  | dir | handshake     | word
//  i_in     | in  | valid/ready   | in_byte, end_of_text
//  o_out    | out | valid/ready   | code_point, replaced, start_offset, byte_length,
//           |     |               | last_result
//  i_cfg_*  | in  | write enable  | replace_nul
//
// One byte is accepted per cycle; words pass the input register and queue, one word per cycle.
// A byte yields zero to four words; the eight-entry result queue sets the pace when
// bytes yield more than one word or the sink stalls.
// Input stalls while the queue holds more than four words and the input register is full.
// Reset is synchronous and active low; no clearing pass.
module utf8_decoder_with_replacement (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);
    import u8d_pkg::*;

    t_push push;
    logic  room;

    u8d_dec u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_room        (room),
        .o_push        (push)
    );

    u8d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

### dv/utf8_decoder_with_replacement_tb.sv
// Testbench: random and directed UTF-8 byte streams checked against a decode model.
module utf8_decoder_with_replacement_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    // Holds the expected code point words and the decoder state that produces them.
    class decode_scoreboard;
        bit          replace_nul;
        bit [2:0]    seq_len;
        bit [2:0]    seq_held;
        bit [20:0]   seq_value;
        bit [16:0]   seq_min;
        bit [31:0]   byte_pos;
        bit [31:0]   seq_start;
        t_result     pending_points[$];
        int unsigned mismatches;

        function new();
            replace_nul = 1'b0;
            byte_pos    = '0;
            seq_start   = '0;
            mismatches  = 0;
            close_seq();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 100) begin
                $display("%0t mismatch: %s", $realtime, what);
            end
        endtask

        function void close_seq();
            seq_len   = '0;
            seq_held  = '0;
            seq_value = '0;
            seq_min   = '0;
        endfunction

        function void push_point(logic [20:0] cp, bit rep, bit [31:0] start, bit [2:0] len);
            t_result r;
            r.code_point   = cp;
            r.replaced     = rep;
            r.start_offset = start;
            r.byte_length  = len;
            r.last_result  = 1'b0;
            pending_points.insert(pending_points.size(), r);
        endfunction

        // one U+FFFD per byte of the open sequence
        function void push_replacements(int count);
            for (int k = 0; k < count && k < 4; k++) begin
                push_point(REPL_CP, 1'b1, seq_start + k, 3'd1);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic eot);
            int        first;
            bit        taken;
            bit [2:0]  len;
            bit [20:0] val;
            bit [16:0] min_val;
            bit [31:0] pos;
            first   = pending_points.size();
            taken   = 1'b0;
            len     = '0;
            val     = '0;
            min_val = '0;
            pos     = byte_pos;

            if (seq_len != 0) begin
                if ((b & CONT_MASK) == CONT_TAG) begin
                    taken     = 1'b1;
                    seq_value = {seq_value[14:0], b[5:0]};
                    seq_held++;
                    if (seq_held >= seq_len) begin
                        // overlong, surrogate and range are only judged on the last byte
                        if (seq_value < seq_min || seq_value > MAX_CP ||
                            (seq_value >= SURR_LO && seq_value <= SURR_HI)) begin
                            push_replacements(int'(seq_len));
                        end else begin
                            push_point(seq_value, 1'b0, seq_start, seq_len);
                        end
                        close_seq();
                    end else if (eot) begin
                        push_replacements(int'(seq_held));
                        close_seq();
                    end
                end else begin
                    // broken sequence; the breaking byte is decoded as a lead below
                    push_replacements(int'(seq_held));
                    close_seq();
                end
            end

            if (!taken) begin
                if (b <= ASCII_HI) begin
                    if (b == 8'h00 && replace_nul) begin
                        push_point(REPL_CP, 1'b1, pos, 3'd1);
                    end else begin
                        push_point({13'd0, b}, 1'b0, pos, 3'd1);
                    end
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    len = 3'd2; val = 21'(b & 8'h1F); min_val = MIN2;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    len = 3'd3; val = 21'(b & 8'h0F); min_val = MIN3;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    len = 3'd4; val = 21'(b & 8'h07); min_val = MIN4;
                end else begin
                    push_point(REPL_CP, 1'b1, pos, 3'd1);
                end
                if (len != 0) begin
                    if (eot) begin
                        push_point(REPL_CP, 1'b1, pos, 3'd1);
                    end else begin
                        seq_len   = len;
                        seq_held  = 3'd1;
                        seq_value = val;
                        seq_min   = min_val;
                        seq_start = pos;
                    end
                end
            end

            if (eot) begin
                if (pending_points.size() > first) begin
                    pending_points[pending_points.size() - 1].last_result = 1'b1;
                end
                byte_pos = '0;
            end else begin
                byte_pos = pos + 1;
            end
        endfunction

        task check_word(t_result got);
            t_result exp;
            string   bad;
            bad = "";
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected word cp=%h off=%0d",
                                          got.code_point, got.start_offset));
                return;
            end
            exp = pending_points.pop_front();
            if (got.code_point !== exp.code_point)     bad = {bad, " code_point"};
            if (got.replaced !== exp.replaced)         bad = {bad, " replaced"};
            if (got.start_offset !== exp.start_offset) bad = {bad, " start_offset"};
            if (got.byte_length !== exp.byte_length)   bad = {bad, " byte_length"};
            if (got.last_result !== exp.last_result)   bad = {bad, " last_result"};
            if (bad != "") begin
                report_mismatch($sformatf(
                    "%s: got %h/%b/%0d/%0d/%b, want %h/%b/%0d/%0d/%b",
                    bad, got.code_point, got.replaced, got.start_offset, got.byte_length,
                    got.last_result, exp.code_point, exp.replaced, exp.start_offset,
                    exp.byte_length, exp.last_result));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    u8d_in_if  in_if();
    u8d_out_if out_if();

    decode_scoreboard scoreboard;
    logic [8:0]       text_q[$];   // {end_of_text, byte}
    int               src_idle_pct;
    int               sink_stall_pct;

    utf8_decoder_with_replacement uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                scoreboard.note_byte(in_if.in_byte, in_if.end_of_text);
            end
            if (out_if.valid && out_if.ready) begin
                got.code_point   = out_if.code_point;
                got.replaced     = out_if.replaced;
                got.start_offset = out_if.start_offset;
                got.byte_length  = out_if.byte_length;
                got.last_result  = out_if.last_result;
                scoreboard.check_word(got);
            end
        end
    end

    function void add_byte(logic [7:0] b);
        text_q.insert(text_q.size(), {($urandom_range(99) < 3) ? 1'b1 : 1'b0, b});
    endfunction

    // encodes v in len bytes without any validity check, emits the first keep bytes
    function void add_encoded(bit [20:0] v, int len, int keep);
        logic [7:0] seq[4];
        case (len)
            2: begin
                seq[0] = {3'b110, v[10:6]};
                seq[1] = {2'b10, v[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, v[15:12]};
                seq[1] = {2'b10, v[11:6]};
                seq[2] = {2'b10, v[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, v[20:18]};
                seq[1] = {2'b10, v[17:12]};
                seq[2] = {2'b10, v[11:6]};
                seq[3] = {2'b10, v[5:0]};
            end
        endcase
        for (int k = 0; k < keep && k < len; k++) begin
            add_byte(seq[k]);
        end
    endfunction

    function void fill_random_text(int count);
        int        pick;
        int        len;
        bit [20:0] v;
        while (text_q.size() < count) begin
            pick = $urandom_range(99);
            len  = $urandom_range(4, 2);
            if (pick < 40) begin
                add_byte(8'($urandom_range(127)));
            end else if (pick < 75) begin
                case (len)
                    2: v = 21'($urandom_range(21'h7FF, 21'h80));
                    3: begin
                        v = 21'($urandom_range(21'hFFFF, 21'h800));
                        if (v >= SURR_LO && v <= SURR_HI) v = v ^ 21'h2000;
                    end
                    default: v = 21'($urandom_range(MAX_CP, 21'h10000));
                endcase
                add_encoded(v, len, len);
            end else if (pick < 87) begin
                add_byte(8'($urandom_range(255)));
            end else if (pick < 94) begin
                // overlong, surrogate or out-of-range forms
                v = 21'($urandom_range((1 << (5 * len + 1)) - 1));
                add_encoded(v, len, len);
            end else begin
                v = 21'($urandom_range(MAX_CP, 21'h10000));
                add_encoded(v, len, $urandom_range(len - 1, 1));
            end
        end
    endfunction

    task automatic send_text();
        logic [8:0] w;
        while (text_q.size() != 0) begin
            w = text_q.pop_front();
            if ($urandom_range(99) < src_idle_pct) begin
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
            end
            in_if.valid       <= 1'b1;
            in_if.in_byte     <= w[7:0];
            in_if.end_of_text <= w[8];
            do @(posedge i_clk); while (!in_if.ready);
        end
        in_if.valid <= 1'b0;
    endtask

    task automatic drain_points();
        int waited;
        waited = 0;
        @(posedge i_clk);
        while (scoreboard.pending_points.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (scoreboard.pending_points.size() != 0) begin
            scoreboard.report_mismatch($sformatf("%0d expected words never came",
                                                 scoreboard.pending_points.size()));
            scoreboard.pending_points.delete();
        end
        // lead bytes yield no word; let the pipeline settle
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_replace_nul(bit v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        scoreboard.replace_nul = v;
    endtask

    task automatic run_phase(bit nul_mode, int src_pct, int sink_pct);
        write_replace_nul(nul_mode);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        fill_random_text(100);
        send_text();
        drain_points();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        in_if.valid       = 1'b0;
        in_if.in_byte     = 8'h00;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        scoreboard        = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // NUL replaced, ASCII top, 2-byte extremes, overlong, surrogate, above range,
        // 4-byte max, bad lead, broken sequence, truncation and lone lead at end of text
        write_replace_nul(1'b1);
        text_q = '{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
                   9'h0E0, 9'h080, 9'h080, 9'h0ED, 9'h0A0, 9'h080,
                   9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                   9'h0FF, 9'h0E2, 9'h082, 9'h041, 9'h0F0, 9'h190, 9'h1C3};
        send_text();
        drain_points();

        run_phase(1'b0, 0, 0);
        run_phase(1'b1, 49, 0);
        run_phase(1'b0, 0, 49);
        run_phase(1'b1, 17, 17);

        if (scoreboard.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
